@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the key event decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form with an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Form that uses the standard clock and reset names of this project.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/ps2kd_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2kd_pkg
// Types, constants and translation tables of the PS/2 key event decoder.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  localparam int QueueDepth = 128;
  localparam int PtrW       = $clog2(QueueDepth);

  localparam logic [7:0] PrefixExt = 8'hE0;
  localparam logic [6:0] ScLShift  = 7'h2A;
  localparam logic [6:0] ScRShift  = 7'h36;
  localparam logic [6:0] ScCtrl    = 7'h1D;
  localparam logic [6:0] ScAlt     = 7'h38;
  localparam logic [6:0] ScCaps    = 7'h3A;

  localparam int ModShift = 0;
  localparam int ModCtrl  = 1;
  localparam int ModAlt   = 2;
  localparam int ModCaps  = 3;

  typedef enum logic {
    ACT_SCAN = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef struct packed {
    logic [4:0] modifiers;
    logic       pressed;
    logic [6:0] ascii;
    logic [7:0] scancode;
  } event_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic nonempty_next;
  } queue_status_t;

  function automatic logic [6:0] rom_plain(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] rom_shift(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h21;
      7'd3:    ch = 7'h40;
      7'd4:    ch = 7'h23;
      7'd5:    ch = 7'h24;
      7'd6:    ch = 7'h25;
      7'd7:    ch = 7'h5E;
      7'd8:    ch = 7'h26;
      7'd9:    ch = 7'h2A;
      7'd10:   ch = 7'h28;
      7'd11:   ch = 7'h29;
      7'd12:   ch = 7'h5F;
      7'd13:   ch = 7'h2B;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h51;
      7'd17:   ch = 7'h57;
      7'd18:   ch = 7'h45;
      7'd19:   ch = 7'h52;
      7'd20:   ch = 7'h54;
      7'd21:   ch = 7'h59;
      7'd22:   ch = 7'h55;
      7'd23:   ch = 7'h49;
      7'd24:   ch = 7'h4F;
      7'd25:   ch = 7'h50;
      7'd26:   ch = 7'h7B;
      7'd27:   ch = 7'h7D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h41;
      7'd31:   ch = 7'h53;
      7'd32:   ch = 7'h44;
      7'd33:   ch = 7'h46;
      7'd34:   ch = 7'h47;
      7'd35:   ch = 7'h48;
      7'd36:   ch = 7'h4A;
      7'd37:   ch = 7'h4B;
      7'd38:   ch = 7'h4C;
      7'd39:   ch = 7'h3A;
      7'd40:   ch = 7'h22;
      7'd41:   ch = 7'h7E;
      7'd43:   ch = 7'h7C;
      7'd44:   ch = 7'h5A;
      7'd45:   ch = 7'h58;
      7'd46:   ch = 7'h43;
      7'd47:   ch = 7'h56;
      7'd48:   ch = 7'h42;
      7'd49:   ch = 7'h4E;
      7'd50:   ch = 7'h4D;
      7'd51:   ch = 7'h3C;
      7'd52:   ch = 7'h3E;
      7'd53:   ch = 7'h3F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/ps2kd_queue.sv @@
// ----------------------------------------------------------------------------
// ps2kd_queue
// Ring buffer of key events with registered read data and combinational status flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2kd_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ps2kd_pkg::queue_ctrl_t   ctrl_i,
  input  ps2kd_pkg::event_t        wdata_i,
  output ps2kd_pkg::queue_status_t status_o,
  output ps2kd_pkg::event_t        rdata_o
);
  import ps2kd_pkg::*;

  event_t          mem [QueueDepth];
  event_t          rdata_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_next, rd_next;

  assign wr_next = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_next = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);

  assign status_o.full          = (wr_next == rd_ptr_q);
  assign status_o.empty         = (wr_ptr_q == rd_ptr_q);
  assign status_o.nonempty_next = (wr_ptr_d != rd_ptr_d);

  assign wr_ptr_d = ctrl_i.push ? wr_next : wr_ptr_q;
  assign rd_ptr_d = ctrl_i.pop ? rd_next : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

  `ASSERT_STD(a_no_push_and_pop, !(ctrl_i.push && ctrl_i.pop),
              "Push and pop requested in the same cycle.")
  `ASSERT_STD(a_no_push_when_full, ctrl_i.push |-> !status_o.full,
              "Push into a full queue.")
  `ASSERT_STD(a_pop_advances, ctrl_i.pop |=> (rd_ptr_q != $past(rd_ptr_q)),
              "Pop did not advance the read pointer.")

endmodule

@@ rtl/ps2_set1_key_event_decoder.sv @@
// ----------------------------------------------------------------------------
// ps2_set1_key_event_decoder
// PS/2 scancode set 1 decoder that queues key events with ASCII translation.
// ----------------------------------------------------------------------------
// Each request on the slave stream is either a raw set 1 scancode byte
// (tuser low) or a read of one queued event (tuser high). A byte of 0xE0
// only arms the extended flag. Other bytes update shift, ctrl, alt and
// caps lock, are translated to US QWERTY ASCII and are pushed as an event
// into a 128-entry ring buffer that holds at most 127 events; a byte that
// finds the buffer full is reported as dropped.
// Every request gives exactly one result on the master stream, in the cycle
// after it is taken. A request is taken in every cycle in which the result
// register is empty or its result is taken in the same cycle, so the block
// sustains one request per clock. The read port of the event buffer is
// registered and feeds the result directly. If the receiver stalls, the
// result register holds its result and the sender is stalled until that
// result is taken.
// Reset empties the buffer, clears all modifiers and the extended flag,
// and leaves the master stream idle. The buffer needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2_set1_key_event_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // scan_byte[7:0]
  input  logic [0:0]  s_axis_tuser_i,   // action[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // dropped[0], event_valid[1],
                                        // ev_scancode[9:2], ev_ascii[16:10],
                                        // ev_pressed[17], ev_modifiers[22:18],
                                        // pending[23]
);
  import ps2kd_pkg::*;

  logic          in_accept;
  action_e       action;
  logic [7:0]    scan_byte;
  logic [6:0]    code;
  logic          released;
  logic          is_scan;
  logic          is_prefix;
  logic [3:0]    held_q, held_d;
  logic          ext_q, ext_d;
  logic [6:0]    plain_ch, shift_ch, ascii;
  logic          is_letter, use_shift;
  event_t        push_event;
  queue_ctrl_t   q_ctrl;
  queue_status_t q_status;
  event_t        q_rdata;
  logic          out_valid_q;
  logic          dropped_q;
  logic          ev_valid_q;
  logic          pending_q;

  assign action    = action_e'(s_axis_tuser_i[0]);
  assign scan_byte = s_axis_tdata_i;
  assign code      = scan_byte[6:0];
  assign released  = scan_byte[7];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign is_scan         = in_accept && (action == ACT_SCAN);
  assign is_prefix       = (scan_byte == PrefixExt);

  always_comb begin
    held_d = held_q;
    ext_d  = ext_q;
    if (is_scan) begin
      if (is_prefix) begin
        ext_d = 1'b1;
      end else begin
        ext_d = 1'b0;
        if (code == ScLShift || code == ScRShift) begin
          held_d[ModShift] = !released;
        end else if (code == ScCtrl) begin
          held_d[ModCtrl] = !released;
        end else if (code == ScAlt) begin
          held_d[ModAlt] = !released;
        end else if (code == ScCaps && !released) begin
          held_d[ModCaps] = !held_q[ModCaps];
        end
      end
    end
  end

  assign plain_ch  = rom_plain(code);
  assign shift_ch  = rom_shift(code);
  assign is_letter = (plain_ch >= 7'h61) && (plain_ch <= 7'h7A);
  assign use_shift = is_letter ? (held_d[ModShift] ^ held_d[ModCaps]) : held_d[ModShift];
  assign ascii     = use_shift ? shift_ch : plain_ch;

  assign push_event.modifiers = {ext_q, held_d};
  assign push_event.pressed   = !released;
  assign push_event.ascii     = ascii;
  assign push_event.scancode  = scan_byte;

  assign q_ctrl.push = is_scan && !is_prefix && !q_status.full;
  assign q_ctrl.pop  = in_accept && (action == ACT_READ) && !q_status.empty;

  ps2kd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (q_ctrl),
    .wdata_i  (push_event),
    .status_o (q_status),
    .rdata_o  (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      ext_q       <= 1'b0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
      ev_valid_q  <= 1'b0;
      pending_q   <= 1'b0;
    end else begin
      held_q <= held_d;
      ext_q  <= ext_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
        dropped_q   <= is_scan && !is_prefix && q_status.full;
        ev_valid_q  <= q_ctrl.pop;
        pending_q   <= q_status.nonempty_next;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {pending_q, (ev_valid_q ? q_rdata : '0), ev_valid_q, dropped_q};

  `ASSERT_STD(a_event_not_dropped, !(ev_valid_q && dropped_q),
              "Result reports both a returned event and a dropped byte.")
  `ASSERT_STD(a_empty_read_gives_nothing,
              (in_accept && action == ACT_READ && q_status.empty) |=> !ev_valid_q,
              "Read of an empty queue returned an event.")
  `ASSERT_STD(a_push_leaves_pending, q_ctrl.push |=> pending_q,
              "Queue reported empty right after a push.")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 set 1 key event decoder.
// ----------------------------------------------------------------------------
// A small scoreboard keeps its own copy of the modifier state, the extended
// flag and the event queue, and works out the result of every accepted
// request. Every result taken from the master stream is compared field by
// field with the oldest expected one. Stimulus is a short directed sequence
// followed by random segments that fill, drain and mix the queue, with
// bursty sending and a changing stall pattern on the result side.
// ----------------------------------------------------------------------------
import ps2kd_pkg::*;

typedef struct packed {
  logic       pending;
  logic [4:0] modifiers;
  logic       pressed;
  logic [6:0] ascii;
  logic [7:0] scancode;
  logic       ev_valid;
  logic       dropped;
} key_result_t;

class key_event_scoreboard;
  key_result_t expected_q[$];
  event_t      queued_events[$];
  logic [3:0]  held_mods;
  logic        ext_armed;
  int unsigned errors;
  logic [6:0]  plain_keys [58];
  logic [6:0]  shifted_keys [58];

  function new();
    held_mods = '0;
    ext_armed = 1'b0;
    errors    = 0;
    plain_keys = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20};
    shifted_keys = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20};
  endfunction

  function logic [6:0] to_ascii(logic [6:0] code, logic [3:0] mods);
    logic [6:0] plain;
    logic       use_shift;
    if (code >= 7'd58) return 7'h00;
    plain = plain_keys[code];
    // Letters follow shift XOR caps lock, everything else follows shift.
    if (plain >= 7'h61 && plain <= 7'h7A) use_shift = mods[ModShift] ^ mods[ModCaps];
    else use_shift = mods[ModShift];
    return use_shift ? shifted_keys[code] : plain;
  endfunction

  function void note_request(action_e act, logic [7:0] scan);
    key_result_t res;
    event_t      ev;
    logic [6:0]  code;
    logic        released;
    res      = '0;
    code     = scan[6:0];
    released = scan[7];
    if (act == ACT_SCAN) begin
      if (scan == PrefixExt) begin
        ext_armed = 1'b1;
      end else begin
        if (code == ScLShift || code == ScRShift) held_mods[ModShift] = !released;
        else if (code == ScCtrl) held_mods[ModCtrl] = !released;
        else if (code == ScAlt) held_mods[ModAlt] = !released;
        else if (code == ScCaps && !released) held_mods[ModCaps] = !held_mods[ModCaps];
        ev.scancode  = scan;
        ev.ascii     = to_ascii(code, held_mods);
        ev.pressed   = !released;
        ev.modifiers = {ext_armed, held_mods};
        if (queued_events.size() < QueueDepth - 1) queued_events.push_back(ev);
        else res.dropped = 1'b1;
        ext_armed = 1'b0;
      end
    end else if (queued_events.size() != 0) begin
      ev            = queued_events.pop_front();
      res.ev_valid  = 1'b1;
      res.scancode  = ev.scancode;
      res.ascii     = ev.ascii;
      res.pressed   = ev.pressed;
      res.modifiers = ev.modifiers;
    end
    res.pending = (queued_events.size() != 0);
    expected_q.push_back(res);
  endfunction

  function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(logic [23:0] data);
    key_result_t got;
    key_result_t exp_res;
    got = data;
    if (expected_q.size() == 0) begin
      $error("unexpected result %06h with no request outstanding", data);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    compare_field("dropped", exp_res.dropped, got.dropped);
    compare_field("event_valid", exp_res.ev_valid, got.ev_valid);
    compare_field("ev_scancode", exp_res.scancode, got.scancode);
    compare_field("ev_ascii", exp_res.ascii, got.ascii);
    compare_field("ev_pressed", exp_res.pressed, got.pressed);
    compare_field("ev_modifiers", exp_res.modifiers, got.modifiers);
    compare_field("pending", exp_res.pending, got.pending);
  endfunction
endclass

module tb_top;
  localparam int StallLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  key_event_scoreboard key_sb = new();
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  ps2_set1_key_event_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // scan_byte[7:0]
    .s_axis_tuser_i  (s_tuser),   // action[0]
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // dropped[0], event_valid[1], ev_scancode[9:2],
                                  // ev_ascii[16:10], ev_pressed[17],
                                  // ev_modifiers[22:18], pending[23]
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) key_sb.note_request(action_e'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) key_sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // The result side switches between stall patterns, each held for a span of random length.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (phase = 0; phase < span; phase++) begin
        @(negedge clk_i);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((phase % 9) < 4);
        endcase
      end
    end
  end

  task automatic send_item(input action_e act, input logic [7:0] scan);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= scan;
    s_tuser  <= act;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_scan_byte();
    logic brk;
    brk = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range(0, 255));
      6: case ($urandom_range(0, 3))
        0: return {brk, ScLShift};
        1: return {brk, ScRShift};
        2: return {brk, ScCtrl};
        default: return {brk, ScAlt};
      endcase
      7: return {brk, ScCaps};
      8: return PrefixExt;
      default: return {brk, 7'($urandom_range(0, 57))};
    endcase
  endfunction

  task automatic run_segment(input int unsigned count, input int unsigned read_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < read_pct) send_item(ACT_READ, 8'($urandom_range(0, 255)));
      else send_item(ACT_SCAN, pick_scan_byte());
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned seg;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(ACT_READ, 8'h00);
    send_item(ACT_SCAN, 8'h00);
    send_item(ACT_SCAN, 8'h1E);
    send_item(ACT_SCAN, {1'b0, ScLShift});
    send_item(ACT_SCAN, 8'h1E);
    send_item(ACT_SCAN, 8'h02);
    send_item(ACT_SCAN, {1'b0, ScCaps});
    send_item(ACT_SCAN, 8'h1E);
    send_item(ACT_SCAN, {1'b1, ScLShift});
    send_item(ACT_SCAN, 8'h9E);
    send_item(ACT_SCAN, {1'b1, ScCaps});
    send_item(ACT_SCAN, {1'b0, ScCtrl});
    send_item(ACT_SCAN, {1'b0, ScAlt});
    send_item(ACT_SCAN, PrefixExt);
    send_item(ACT_SCAN, PrefixExt);
    send_item(ACT_SCAN, {1'b1, ScCtrl});
    send_item(ACT_SCAN, {1'b1, ScAlt});
    send_item(ACT_SCAN, {1'b0, ScRShift});
    send_item(ACT_SCAN, {1'b1, ScRShift});
    send_item(ACT_SCAN, 8'hE1);
    send_item(ACT_SCAN, 8'hFF);
    send_item(ACT_SCAN, 8'h7F);
    send_item(ACT_SCAN, 8'h80);
    send_item(ACT_READ, PrefixExt);
    send_item(ACT_READ, 8'hFF);

    // The first random segment is always the scan-heavy kind, sized to push more than the queue holds.
    sent = 0;
    seg  = 0;
    while (sent < 560) begin
      case ((seg == 0) ? 0 : $urandom_range(0, 2))
        0: begin
          run_segment(170, 3);
          sent += 170;
        end
        1: begin
          run_segment(80, 85);
          sent += 80;
        end
        default: begin
          run_segment(50, 45);
          sent += 50;
        end
      endcase
      seg++;
    end
    s_tvalid <= 1'b0;

    while (key_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (key_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
